// ===== design/assert_macros.svh =====
// Assertion macros used by the intern table top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition on the same edge
`define ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// condition in the next cycle
`define ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== design/hsit_pkg.sv =====
// Package for the string intern table: sizes, status codes, slot layout, hash step
`default_nettype none
package hsit_pkg;
  localparam int STORE_BYTES   = 4096;
  localparam int TABLE_ENTRIES = 64;
  localparam int MAX_KEY_LEN   = 64;

  localparam int SA_W   = $clog2(STORE_BYTES);
  localparam int FILL_W = $clog2(STORE_BYTES + 1);
  localparam int SLOT_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int KEY_W  = $clog2(MAX_KEY_LEN);
  localparam int LEN_W  = $clog2(MAX_KEY_LEN + 1);

  localparam logic [63:0] HASH_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] PRIME_LOW  = 64'h1b3;
  localparam int PRIME_SHIFT = 40;

  localparam int LOAD_NUM = 7;
  localparam int LOAD_DEN = 10;
  localparam int FULL_AT  = (TABLE_ENTRIES * LOAD_NUM + LOAD_DEN - 1) / LOAD_DEN;

  localparam logic [1:0] FUNC_KEY   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_EMPTY = 2'd2;

  localparam logic [2:0] ST_INSERTED   = 3'd0;
  localparam logic [2:0] ST_FOUND      = 3'd1;
  localparam logic [2:0] ST_EMPTY      = 3'd2;
  localparam logic [2:0] ST_TOO_LONG   = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL = 3'd4;
  localparam logic [2:0] ST_STORE_FULL = 3'd5;

  typedef struct packed {
    logic [63:0]      hash;
    logic [SA_W-1:0]  offset;
    logic [LEN_W-1:0] len;
  } slot_t;

  // FNV-1a step: xor the byte, multiply by 2^40 + 0x1b3
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << PRIME_SHIFT) + x * PRIME_LOW;
  endfunction
endpackage
`default_nettype wire

// ===== design/hsit_ifs.sv =====
// Channel interfaces: key byte items in, intern result items out
`default_nettype none
interface hsit_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] key_byte;
  logic       last;
  modport source(output valid, func, key_byte, last, input ready);
  modport sink(input valid, func, key_byte, last, output ready);
endinterface

interface hsit_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [11:0] string_offset;
  logic [63:0] key_hash;
  logic [12:0] bytes_used;
  logic [6:0]  strings_held;
  modport source(output valid, status, string_offset, key_hash, bytes_used, strings_held,
                 input ready);
  modport sink(input valid, status, string_offset, key_hash, bytes_used, strings_held,
               output ready);
endinterface
`default_nettype wire

// ===== design/hashed_string_intern_table.sv =====
// Top level of the string intern table: hashing, probe sequencer, stores
//
//  channel  dir  payload                                               handshake
//  key_in   in   func, key_byte, last                                  valid/ready
//  result   out  status, string_offset, key_hash, bytes_used,          valid/ready
//               strings_held
//
// A key byte that is not last is taken while idle. The last byte of a key
// that fits then probes: a read and a check state per slot visited and per
// byte compared on a hash and length hit, a read and a write state per byte
// copied, a terminator on insert: slot, key and byte RAMs have registered reads.
// Reset is synchronous and clears the table at once (used bits in flops).
// key_in is held off while a probe runs or while an unread result is pending.
`default_nettype none
`include "assert_macros.svh"
module hashed_string_intern_table
  import hsit_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst,
  hsit_in_if.sink    key_in,
  hsit_out_if.source result
);
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SLOT_RD = 3'd1;
  localparam logic [2:0] S_SLOT_CK = 3'd2;
  localparam logic [2:0] S_CMP_RD  = 3'd3;
  localparam logic [2:0] S_CMP_CK  = 3'd4;
  localparam logic [2:0] S_COPY_RD = 3'd5;
  localparam logic [2:0] S_COPY_WR = 3'd6;
  localparam logic [2:0] S_TERM    = 3'd7;

  logic [2:0]         state;
  logic [63:0]        running_hash;
  logic [LEN_W-1:0]   key_length;
  logic               key_overflow;
  logic [FILL_W-1:0]  store_fill;
  logic [CNT_W-1:0]   entry_count;
  logic [TABLE_ENTRIES-1:0] slot_used;

  logic [63:0]        fin_hash;
  logic [LEN_W-1:0]   fin_len;
  logic [SLOT_W-1:0]  probe;
  logic [SLOT_W-1:0]  visits;
  logic [LEN_W-1:0]   idx;

  logic               out_valid;
  logic [2:0]         out_status;
  logic [SA_W-1:0]    out_offset;
  logic [63:0]        out_hash;
  logic [FILL_W-1:0]  out_used;
  logic [CNT_W-1:0]   out_held;

  logic               acc;
  logic [63:0]        hash_nx;
  slot_t              slot_q;
  slot_t              slot_new;
  logic               slot_we;
  logic [7:0]         kb_q;
  logic [7:0]         bs_q;
  logic               bs_we;
  logic [SA_W-1:0]    bs_waddr;
  logic [7:0]         bs_wdata;
  logic [SA_W-1:0]    bs_raddr;
  logic               kb_we;
  logic               table_full;
  logic               store_full;
  logic               last_visit;

  assign key_in.ready = (state == S_IDLE) && (!out_valid || result.ready);
  assign acc          = key_in.valid && key_in.ready;
  assign hash_nx      = fnv_step(running_hash, key_in.key_byte);

  assign result.valid         = out_valid;
  assign result.status        = out_status;
  assign result.string_offset = out_offset;
  assign result.key_hash      = out_hash;
  assign result.bytes_used    = out_used;
  assign result.strings_held  = out_held;

  assign table_full = ({1'b0, entry_count} + 1'b1) >= (CNT_W + 1)'(FULL_AT);
  assign store_full = ({1'b0, store_fill} + (FILL_W + 1)'(fin_len) + 1'b1)
                      > (FILL_W + 1)'(STORE_BYTES);
  assign last_visit = (visits == SLOT_W'(TABLE_ENTRIES - 1));

  assign kb_we    = acc && (key_in.func == FUNC_KEY) && (key_length < LEN_W'(MAX_KEY_LEN));
  assign bs_raddr = slot_q.offset + SA_W'(idx);
  assign bs_we    = (state == S_COPY_WR) || (state == S_TERM);
  assign bs_waddr = store_fill[SA_W-1:0] + SA_W'(idx);
  assign bs_wdata = (state == S_TERM) ? 8'd0 : kb_q;
  assign slot_we  = (state == S_TERM);
  assign slot_new = '{hash: fin_hash, offset: store_fill[SA_W-1:0], len: fin_len};

  hsit_ram #(.WIDTH($bits(slot_t)), .DEPTH(TABLE_ENTRIES)) u_slots (
    .clk, .we(slot_we), .waddr(probe), .wdata(slot_new), .raddr(probe), .rdata(slot_q)
  );

  hsit_ram #(.WIDTH(8), .DEPTH(MAX_KEY_LEN)) u_keybuf (
    .clk, .we(kb_we), .waddr(key_length[KEY_W-1:0]), .wdata(key_in.key_byte),
    .raddr(idx[KEY_W-1:0]), .rdata(kb_q)
  );

  hsit_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
    .clk, .we(bs_we), .waddr(bs_waddr), .wdata(bs_wdata), .raddr(bs_raddr), .rdata(bs_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      running_hash <= HASH_BASIS;
      key_length   <= '0;
      key_overflow <= 1'b0;
      store_fill   <= '0;
      entry_count  <= '0;
      slot_used    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            case (key_in.func)
              FUNC_KEY: begin
                if (key_length < LEN_W'(MAX_KEY_LEN)) begin
                  key_length <= key_length + 1'b1;
                end
                if (!key_in.last) begin
                  running_hash <= hash_nx;
                  if (key_length == LEN_W'(MAX_KEY_LEN)) begin
                    key_overflow <= 1'b1;
                  end
                end else begin
                  running_hash <= HASH_BASIS;
                  key_length   <= '0;
                  key_overflow <= 1'b0;
                  if (key_overflow || key_length == LEN_W'(MAX_KEY_LEN)) begin
                    out_valid  <= 1'b1;
                    out_status <= ST_TOO_LONG;
                    out_offset <= '0;
                    out_hash   <= hash_nx;
                    out_used   <= store_fill;
                    out_held   <= entry_count;
                  end else begin
                    fin_hash <= hash_nx;
                    fin_len  <= key_length + 1'b1;
                    probe    <= hash_nx[SLOT_W-1:0];
                    visits   <= '0;
                    state    <= S_SLOT_RD;
                  end
                end
              end
              FUNC_CLEAR: begin
                slot_used    <= '0;
                store_fill   <= '0;
                entry_count  <= '0;
                running_hash <= HASH_BASIS;
                key_length   <= '0;
                key_overflow <= 1'b0;
              end
              FUNC_EMPTY: begin
                out_valid  <= 1'b1;
                out_status <= ST_EMPTY;
                out_offset <= '0;
                out_hash   <= HASH_BASIS;
                out_used   <= store_fill;
                out_held   <= entry_count;
              end
              default: begin
              end
            endcase
          end
        end
        S_SLOT_RD: begin
          state <= S_SLOT_CK;
        end
        S_SLOT_CK: begin
          idx <= '0;
          if (!slot_used[probe]) begin
            if (table_full || store_full) begin
              out_valid  <= 1'b1;
              out_status <= table_full ? ST_TABLE_FULL : ST_STORE_FULL;
              out_offset <= '0;
              out_hash   <= fin_hash;
              out_used   <= store_fill;
              out_held   <= entry_count;
              state      <= S_IDLE;
            end else begin
              state <= S_COPY_RD;
            end
          end else if (slot_q.hash == fin_hash && slot_q.len == fin_len) begin
            state <= S_CMP_RD;
          end else if (last_visit) begin
            out_valid  <= 1'b1;
            out_status <= ST_TABLE_FULL;
            out_offset <= '0;
            out_hash   <= fin_hash;
            out_used   <= store_fill;
            out_held   <= entry_count;
            state      <= S_IDLE;
          end else begin
            probe  <= probe + 1'b1;
            visits <= visits + 1'b1;
            state  <= S_SLOT_RD;
          end
        end
        S_CMP_RD: begin
          state <= S_CMP_CK;
        end
        S_CMP_CK: begin
          if (bs_q != kb_q) begin
            if (last_visit) begin
              out_valid  <= 1'b1;
              out_status <= ST_TABLE_FULL;
              out_offset <= '0;
              out_hash   <= fin_hash;
              out_used   <= store_fill;
              out_held   <= entry_count;
              state      <= S_IDLE;
            end else begin
              probe  <= probe + 1'b1;
              visits <= visits + 1'b1;
              state  <= S_SLOT_RD;
            end
          end else if (idx + 1'b1 == fin_len) begin
            out_valid  <= 1'b1;
            out_status <= ST_FOUND;
            out_offset <= slot_q.offset;
            out_hash   <= fin_hash;
            out_used   <= store_fill;
            out_held   <= entry_count;
            state      <= S_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_CMP_RD;
          end
        end
        S_COPY_RD: begin
          state <= S_COPY_WR;
        end
        S_COPY_WR: begin
          idx   <= idx + 1'b1;
          state <= (idx + 1'b1 == fin_len) ? S_TERM : S_COPY_RD;
        end
        S_TERM: begin
          slot_used[probe] <= 1'b1;
          entry_count      <= entry_count + 1'b1;
          store_fill       <= store_fill + FILL_W'(fin_len) + 1'b1;
          out_valid  <= 1'b1;
          out_status <= ST_INSERTED;
          out_offset <= store_fill[SA_W-1:0];
          out_hash   <= fin_hash;
          out_used   <= store_fill + FILL_W'(fin_len) + 1'b1;
          out_held   <= entry_count + 1'b1;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPL(a_count_bound, 1'b1, entry_count < CNT_W'(FULL_AT))
  `ASSERT_IMPL(a_fill_bound, 1'b1, store_fill <= FILL_W'(STORE_BYTES))
  `ASSERT_IMPL(a_cmp_len, state == S_CMP_CK, slot_q.len == fin_len && idx < fin_len)
  `ASSERT_NEXT(a_term_result, state == S_TERM, out_valid && out_status == ST_INSERTED)
endmodule
`default_nettype wire

// ===== design/hsit_ram.sv =====
// Generic single write port, single read port RAM with registered read
`default_nettype none
module hsit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
